// ===== design/assert_macros.svh =====
// Assertion shorthands included by the transform unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i, muted while rst_i is high.
`define QPT_ASSERT(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define QPT_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/qpt_pkg.sv =====
`default_nettype none

package qpt_pkg;

  // Fixed field widths of the point and result words
  localparam int COORD_WIDTH = 32;
  // Default quaternion register width (signed Q1.(QUAT_WIDTH-1))
  localparam int QUAT_WIDTH  = 16;
  // Register index width of the configuration port
  localparam int CFG_IDX_W   = 3;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W  = CFG_IDX_W'(0),
    REG_QUAT_X  = CFG_IDX_W'(1),
    REG_QUAT_Y  = CFG_IDX_W'(2),
    REG_QUAT_Z  = CFG_IDX_W'(3),
    REG_SHIFT_X = CFG_IDX_W'(4),
    REG_SHIFT_Y = CFG_IDX_W'(5),
    REG_SHIFT_Z = CFG_IDX_W'(6)
  } reg_idx_t;

  // Input word: one world point, signed Q16.16
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } point_t;

  // Output word: camera-space point and camera center, signed Q16.16
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cam_x;
    logic signed [COORD_WIDTH-1:0] cam_y;
    logic signed [COORD_WIDTH-1:0] cam_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
  } result_t;

  // Load enables of the three dot-product stages
  typedef struct packed {
    logic prod;
    logic sum;
    logic rnd;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== design/qpt_dot3.sv =====
`default_nettype none

// Three-term dot product of a rotation row and a vector, rounded once.
// Stage 1: split products, stage 2: partial sums, stage 3: merge and round.
module qpt_dot3 #(
  parameter int RW    = 34,
  parameter int VW    = 33,
  parameter int FRAC  = 30,
  parameter int SPLIT = 17
) (
  input  wire logic                          clk,
  input  wire qpt_pkg::stage_en_t            en,
  input  wire logic signed [RW-1:0]          r_row [3],
  input  wire logic signed [VW-1:0]          vec [3],
  output logic signed [RW+VW+3-FRAC-1:0]     rnd
);

  localparam int HW = RW - SPLIT + VW;
  localparam int LW = SPLIT + 1 + VW;
  localparam int AW = HW + 2;
  localparam int BW = LW + 2;
  localparam int FW = RW + VW + 3;
  localparam logic signed [FW-1:0] HALF = FW'(1) <<< (FRAC - 1);

  logic signed [RW-SPLIT-1:0] rh [3];
  logic signed [SPLIT:0]      rl [3];
  logic signed [HW-1:0]       ph [3];
  logic signed [LW-1:0]       pl [3];
  logic signed [AW-1:0]       sa;
  logic signed [BW-1:0]       sb;
  logic signed [FW-1:0]       full;

  // Split each entry: signed high part, unsigned low part
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rh[j] = r_row[j][RW-1:SPLIT];
      rl[j] = {1'b0, r_row[j][SPLIT-1:0]};
    end
  end

  // Stage 1: six narrow products
  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int j = 0; j < 3; j++) begin
        ph[j] <= HW'(rh[j]) * HW'(vec[j]);
        pl[j] <= LW'(rl[j]) * LW'(vec[j]);
      end
    end
  end

  // Stage 2: sum high and low partials separately
  always_ff @(posedge clk) begin
    if (en.sum) begin
      sa <= AW'(ph[0]) + AW'(ph[1]) + AW'(ph[2]);
      sb <= BW'(pl[0]) + BW'(pl[1]) + BW'(pl[2]);
    end
  end

  // Stage 3: exact sum, round to nearest with ties up
  assign full = (FW'(sa) <<< SPLIT) + FW'(sb) + HALF;

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      rnd <= full[FW-1:FRAC];
    end
  end

endmodule

`default_nettype wire

// ===== design/quaternion_pose_point_transform_unit.sv =====
`default_nettype none

// Rigid transform of world points into camera space. The pose is a quaternion
// (w, x, y, z, signed Q1.15 at the default width) and a world-to-camera shift
// (signed Q16.16) held in seven write-only registers. Each accepted point word
// gives one result word: cam = R*p + shift and center = -R^T*shift, each
// product sum rounded once to Q16.16 (nearest, ties up) and then saturated to
// 32 bits. The datapath is a five-register pipeline (point capture, products,
// partial sums, rounding, shift add and saturation), so one point is taken
// every clock while the result side does not stall. A stall on the result side
// holds the occupied stages while words behind them close up any gaps; the
// point input stalls only once all five registers hold words. The rate is set
// by the 18 split multipliers of the camera-space rows working in parallel.
// The rotation matrix and the center inputs are registered from the pose
// registers: a point may be accepted from the first edge after a register
// write on, but not at the write edge itself.
module quaternion_pose_point_transform_unit #(
  parameter int QUAT_WIDTH = qpt_pkg::QUAT_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // point channel
  input  wire logic                                pt_valid,
  output logic                                     pt_stall,
  input  wire qpt_pkg::point_t                     pt_word,
  // result channel
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output qpt_pkg::result_t                         res_word,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [qpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [qpt_pkg::COORD_WIDTH-1:0]     cfg_data
);

  `include "assert_macros.svh"

  localparam int CW    = qpt_pkg::COORD_WIDTH;
  localparam int QW    = QUAT_WIDTH;
  localparam int QP_W  = 2 * QW;
  localparam int RW    = 2 * QW + 2;
  localparam int VW    = CW + 1;
  localparam int FRAC  = 2 * QW - 2;
  localparam int SPLIT = RW / 2;
  localparam int RND_W = RW + VW + 3 - FRAC;
  localparam int SUM_W = RND_W + 1;
  localparam logic signed [RW-1:0] ONE = RW'(1) <<< FRAC;

  // Pose registers
  logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [CW-1:0] shift [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w <= {1'b0, {(QW-1){1'b1}}};
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      for (int i = 0; i < 3; i++) begin
        shift[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (qpt_pkg::reg_idx_t'(cfg_index))
        qpt_pkg::REG_QUAT_W:  quat_w   <= cfg_data[QW-1:0];
        qpt_pkg::REG_QUAT_X:  quat_x   <= cfg_data[QW-1:0];
        qpt_pkg::REG_QUAT_Y:  quat_y   <= cfg_data[QW-1:0];
        qpt_pkg::REG_QUAT_Z:  quat_z   <= cfg_data[QW-1:0];
        qpt_pkg::REG_SHIFT_X: shift[0] <= cfg_data[CW-1:0];
        qpt_pkg::REG_SHIFT_Y: shift[1] <= cfg_data[CW-1:0];
        qpt_pkg::REG_SHIFT_Z: shift[2] <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Quaternion products
  logic signed [QP_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;

  assign pxx = QP_W'(quat_x) * QP_W'(quat_x);
  assign pyy = QP_W'(quat_y) * QP_W'(quat_y);
  assign pzz = QP_W'(quat_z) * QP_W'(quat_z);
  assign pxy = QP_W'(quat_x) * QP_W'(quat_y);
  assign pxz = QP_W'(quat_x) * QP_W'(quat_z);
  assign pyz = QP_W'(quat_y) * QP_W'(quat_z);
  assign pwx = QP_W'(quat_w) * QP_W'(quat_x);
  assign pwy = QP_W'(quat_w) * QP_W'(quat_y);
  assign pwz = QP_W'(quat_w) * QP_W'(quat_z);

  // Rotation matrix, Q(FRAC)
  logic signed [RW-1:0] m_next [3][3];

  always_comb begin
    m_next[0][0] = ONE - ((RW'(pyy) + RW'(pzz)) <<< 1);
    m_next[0][1] = (RW'(pxy) - RW'(pwz)) <<< 1;
    m_next[0][2] = (RW'(pxz) + RW'(pwy)) <<< 1;
    m_next[1][0] = (RW'(pxy) + RW'(pwz)) <<< 1;
    m_next[1][1] = ONE - ((RW'(pxx) + RW'(pzz)) <<< 1);
    m_next[1][2] = (RW'(pyz) - RW'(pwx)) <<< 1;
    m_next[2][0] = (RW'(pxz) - RW'(pwy)) <<< 1;
    m_next[2][1] = (RW'(pyz) + RW'(pwx)) <<< 1;
    m_next[2][2] = ONE - ((RW'(pxx) + RW'(pyy)) <<< 1);
  end

  // Matrix, its transpose and the negated shift, rebuilt every cycle
  logic signed [RW-1:0] r_mat [3][3];
  logic signed [RW-1:0] r_col [3][3];
  logic signed [VW-1:0] neg_t [3];

  always_ff @(posedge clk) begin
    r_mat <= m_next;
    for (int i = 0; i < 3; i++) begin
      neg_t[i] <= -VW'(shift[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r_col[i][j] = r_mat[j][i];
      end
    end
  end

  // Pipeline flow control: a stage loads when it is empty or drains
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  qpt_pkg::stage_en_t cam_en;
  qpt_pkg::stage_en_t ctr_en;

  assign rdy_out  = !res_valid || !res_stall;
  assign rdy4     = !s4_valid || rdy_out;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign pt_stall = !rdy1;

  assign cam_en = '{prod: rdy2, sum: rdy3, rnd: rdy4};
  assign ctr_en = '{prod: 1'b1, sum: 1'b1, rnd: 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rdy1)    s1_valid  <= pt_valid;
      if (rdy2)    s2_valid  <= s1_valid;
      if (rdy3)    s3_valid  <= s2_valid;
      if (rdy4)    s4_valid  <= s3_valid;
      if (rdy_out) res_valid <= s4_valid;
    end
  end

  // Point capture
  logic signed [VW-1:0] s1_pt [3];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_pt[0] <= VW'(pt_word.point_x);
      s1_pt[1] <= VW'(pt_word.point_y);
      s1_pt[2] <= VW'(pt_word.point_z);
    end
  end

  // Camera rows R*p and center rows R^T*(-t)
  logic signed [RND_W-1:0] cam_rnd [3];
  logic signed [RND_W-1:0] ctr_rnd [3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    qpt_dot3 #(
      .RW    (RW),
      .VW    (VW),
      .FRAC  (FRAC),
      .SPLIT (SPLIT)
    ) u_cam (
      .clk   (clk),
      .en    (cam_en),
      .r_row (r_mat[i]),
      .vec   (s1_pt),
      .rnd   (cam_rnd[i])
    );

    qpt_dot3 #(
      .RW    (RW),
      .VW    (VW),
      .FRAC  (FRAC),
      .SPLIT (SPLIT)
    ) u_ctr (
      .clk   (clk),
      .en    (ctr_en),
      .r_row (r_col[i]),
      .vec   (neg_t),
      .rnd   (ctr_rnd[i])
    );
  end

  // Clamp to the signed output range
  function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-CW:0] top;
    top = v[SUM_W-1:CW-1];
    priority if (&top || !(|top)) begin
      return v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // Output word register: shift add and saturation
  always_ff @(posedge clk) begin
    if (rdy_out) begin
      res_word.cam_x    <= sat(SUM_W'(cam_rnd[0]) + SUM_W'(shift[0]));
      res_word.cam_y    <= sat(SUM_W'(cam_rnd[1]) + SUM_W'(shift[1]));
      res_word.cam_z    <= sat(SUM_W'(cam_rnd[2]) + SUM_W'(shift[2]));
      res_word.center_x <= sat(SUM_W'(ctr_rnd[0]));
      res_word.center_y <= sat(SUM_W'(ctr_rnd[1]));
      res_word.center_z <= sat(SUM_W'(ctr_rnd[2]));
    end
  end

  // Checks
  `QPT_ASSERT(a_accept_enters, clk, rst, pt_valid && !pt_stall |=> s1_valid, "accepted word lost at capture")
  `QPT_ASSERT(a_drain_to_out, clk, rst, s4_valid && rdy_out |=> res_valid, "rounded word did not reach output")
  `QPT_ASSERT(a_stall_only_full, clk, rst, pt_stall |-> s1_valid && s2_valid && s3_valid && s4_valid && res_valid, "stall with a free stage")
  `QPT_ASSERT(a_hold_on_stall, clk, rst, res_valid && res_stall && s4_valid && s3_valid |=> s4_valid && s3_valid, "stage moved under output stall")
  `QPT_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !res_valid && !s1_valid, "pipeline not cleared by reset")

endmodule

`default_nettype wire

// ===== bench/quaternion_pose_point_transform_unit_tb.sv =====
`timescale 1ns / 100ps

module quaternion_pose_point_transform_unit_tb;

  localparam int QUAT_WIDTH   = qpt_pkg::QUAT_WIDTH;
  localparam int COORD_WIDTH  = qpt_pkg::COORD_WIDTH;
  localparam int CFG_IDX_W    = qpt_pkg::CFG_IDX_W;
  localparam int PIPE_LAT     = 4;        // accept edge to result valid
  localparam int ROT_FRAC     = 2 * (QUAT_WIDTH - 1);
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_POINTS = 92;
  localparam int HOLD_PHASE   = 3;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

  typedef logic signed [127:0] wide_t;

  // Pose predictor and store of expected result words
  class pose_scoreboard;
    logic signed [QUAT_WIDTH-1:0]  quat [4];
    logic signed [COORD_WIDTH-1:0] shift [3];
    qpt_pkg::result_t pending_results [$];
    int errors;
    string field_name [6] = '{"cam_x", "cam_y", "cam_z",
                              "center_x", "center_y", "center_z"};

    function new();
      quat[0] = QUAT_WIDTH'((1 <<< (QUAT_WIDTH - 1)) - 1);
      quat[1] = '0;
      quat[2] = '0;
      quat[3] = '0;
      shift[0] = '0;
      shift[1] = '0;
      shift[2] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_WIDTH-1:0] data);
      case (idx)
        qpt_pkg::REG_QUAT_W:  quat[0] = data[QUAT_WIDTH-1:0];
        qpt_pkg::REG_QUAT_X:  quat[1] = data[QUAT_WIDTH-1:0];
        qpt_pkg::REG_QUAT_Y:  quat[2] = data[QUAT_WIDTH-1:0];
        qpt_pkg::REG_QUAT_Z:  quat[3] = data[QUAT_WIDTH-1:0];
        qpt_pkg::REG_SHIFT_X: shift[0] = data;
        qpt_pkg::REG_SHIFT_Y: shift[1] = data;
        qpt_pkg::REG_SHIFT_Z: shift[2] = data;
        default: ;  // unmapped index: write is dropped
      endcase
    endfunction

    // round to Q16.16 (nearest, ties up), add offset, clamp to 32 bits
    function logic [COORD_WIDTH-1:0] round_sat(wide_t acc, wide_t offset);
      wide_t v;
      wide_t hi;
      wide_t lo;
      v = ((acc + (wide_t'(1) <<< (ROT_FRAC - 1))) >>> ROT_FRAC) + offset;
      hi = (wide_t'(1) <<< (COORD_WIDTH - 1)) - wide_t'(1);
      lo = -hi - wide_t'(1);
      if (v > hi) v = hi;
      else if (v < lo) v = lo;
      return v[COORD_WIDTH-1:0];
    endfunction

    // build R from the quaternion, then cam = R*p + t and center = -R^T*t
    function void note_point(qpt_pkg::point_t p);
      wide_t qw, qx, qy, qz, unity, acc;
      wide_t rot [3][3];
      wide_t pv [3];
      wide_t tv [3];
      logic [COORD_WIDTH-1:0] outv [6];
      qpt_pkg::result_t want;
      qw = wide_t'(quat[0]);
      qx = wide_t'(quat[1]);
      qy = wide_t'(quat[2]);
      qz = wide_t'(quat[3]);
      unity = wide_t'(1) <<< ROT_FRAC;
      pv[0] = wide_t'(p.point_x);
      pv[1] = wide_t'(p.point_y);
      pv[2] = wide_t'(p.point_z);
      for (int i = 0; i < 3; i++) tv[i] = wide_t'(shift[i]);
      rot[0][0] = unity - 2 * (qy * qy + qz * qz);
      rot[0][1] = 2 * (qx * qy - qz * qw);
      rot[0][2] = 2 * (qx * qz + qy * qw);
      rot[1][0] = 2 * (qx * qy + qz * qw);
      rot[1][1] = unity - 2 * (qx * qx + qz * qz);
      rot[1][2] = 2 * (qy * qz - qx * qw);
      rot[2][0] = 2 * (qx * qz - qy * qw);
      rot[2][1] = 2 * (qy * qz + qx * qw);
      rot[2][2] = unity - 2 * (qx * qx + qy * qy);
      for (int i = 0; i < 3; i++) begin
        acc = '0;
        for (int j = 0; j < 3; j++) acc += rot[i][j] * pv[j];
        outv[i] = round_sat(acc, tv[i]);
        acc = '0;
        for (int j = 0; j < 3; j++) acc += -rot[j][i] * tv[j];
        outv[3 + i] = round_sat(acc, wide_t'(0));
      end
      want.cam_x    = outv[0];
      want.cam_y    = outv[1];
      want.cam_z    = outv[2];
      want.center_x = outv[3];
      want.center_y = outv[4];
      want.center_z = outv[5];
      pending_results.push_back(want);
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(qpt_pkg::result_t got);
      qpt_pkg::result_t want;
      logic [COORD_WIDTH-1:0] w_f, g_f;
      if (pending_results.size() == 0) begin
        log_error($sformatf("unexpected result word %h", got));
        return;
      end
      want = pending_results.pop_front();
      for (int k = 0; k < 6; k++) begin
        w_f = want[(5 - k) * COORD_WIDTH +: COORD_WIDTH];
        g_f = got[(5 - k) * COORD_WIDTH +: COORD_WIDTH];
        if (g_f !== w_f)
          log_error($sformatf("mismatch %s: expected %0d (%h) got %0d (%h)", field_name[k],
                              $signed(w_f), w_f, $signed(g_f), g_f));
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   pt_valid  = 1'b0;
  logic                   pt_stall;
  qpt_pkg::point_t        pt_word   = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  qpt_pkg::result_t       res_word;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data  = '0;

  pose_scoreboard pose_sb = new();
  int idle_rate = 1;       // 0 turns idling off on both sides
  bit hold_go   = 1'b0;    // asks the result side for a long hold-off

  logic [COORD_WIDTH-1:0] corner_vals [9] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0001_0000, 32'hFFFF_0000, 32'h0000_0003, 32'hFFFF_FFFD};
  logic [QUAT_WIDTH-1:0] quat_picks [8] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h5A82, 16'hA57E, 16'h4000, 16'hC000, 16'h0001};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quaternion_pose_point_transform_unit u_top (
    .clk(clk),
    .rst(rst),
    .pt_valid(pt_valid),
    .pt_stall(pt_stall),
    .pt_word(pt_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word(res_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Watchdog
  initial begin : watchdog
    int cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Result side: check accepted words, stall in random bursts or one long hold
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) pose_sb.check_result(res_word);
      if (hold_go) begin
        hold_go = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_rate != 0 &&
                   $urandom_range(0, 15) < idle_rate * 2) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 3))
      0: return COORD_WIDTH'($urandom);
      1: begin
        v = $urandom_range(0, 4194304);
        return COORD_WIDTH'(v - 2097152);
      end
      2: return corner_vals[$urandom_range(0, 8)];
      default: begin
        v = $urandom_range(0, 512);
        return COORD_WIDTH'((v - 256) * 65536 + int'($urandom_range(0, 65535)));
      end
    endcase
  endfunction

  function automatic logic [QUAT_WIDTH-1:0] rand_quat();
    int v;
    case ($urandom_range(0, 2))
      0: return QUAT_WIDTH'($urandom);
      1: return quat_picks[$urandom_range(0, 7)];
      default: begin
        v = $urandom_range(0, 32768);
        return QUAT_WIDTH'(v - 16384);
      end
    endcase
  endfunction

  // One point word, with an optional gap ahead of it
  task automatic send_point(input qpt_pkg::point_t p);
    if (idle_rate != 0 && $urandom_range(0, 15) < idle_rate * 2) begin
      pt_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pt_valid <= 1'b1;
    pt_word  <= p;
    do @(posedge clk); while (pt_stall);
    pose_sb.note_point(p);
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    pose_sb.set_reg(idx, data);
  endtask

  // Full pose load; quaternion writes carry junk in the unused upper bits
  task automatic load_pose(input logic [QUAT_WIDTH-1:0] qw, qx, qy, qz,
                           input logic [COORD_WIDTH-1:0] sx, sy, sz);
    load_reg(qpt_pkg::REG_QUAT_W, {(COORD_WIDTH - QUAT_WIDTH)'($urandom), qw});
    load_reg(qpt_pkg::REG_QUAT_X, {(COORD_WIDTH - QUAT_WIDTH)'($urandom), qx});
    load_reg(qpt_pkg::REG_QUAT_Y, {(COORD_WIDTH - QUAT_WIDTH)'($urandom), qy});
    load_reg(qpt_pkg::REG_QUAT_Z, {(COORD_WIDTH - QUAT_WIDTH)'($urandom), qz});
    load_reg(qpt_pkg::REG_SHIFT_X, sx);
    load_reg(qpt_pkg::REG_SHIFT_Y, sy);
    load_reg(qpt_pkg::REG_SHIFT_Z, sz);
    load_reg(REG_UNUSED, COORD_WIDTH'($urandom));
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Stop offering and wait for the pipeline to empty
  task automatic settle();
    pt_valid <= 1'b0;
    do @(posedge clk); while (pose_sb.pending() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Main sequence
  initial begin : stimulus
    qpt_pkg::point_t p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pose: corner values in every field
    for (int k = 0; k < 9; k++) begin
      p.point_x = corner_vals[k];
      p.point_y = corner_vals[(k + 3) % 9];
      p.point_z = corner_vals[(k + 6) % 9];
      send_point(p);
    end

    // most negative quaternion, extreme shifts: saturation
    settle();
    load_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});

    // half-weight rotation terms: odd points land exactly on rounding ties
    settle();
    load_pose(16'h0000, 16'h0000, 16'h0000, 16'h4000,
              32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
    send_point('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003});
    send_point('{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFD});
    send_point('{32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0001});
    send_point('{32'hFFFF_FFFD, 32'h0000_0003, 32'hFFFF_FFFF});
    send_point('{32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0005});
    send_point('{32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFB});

    // random phases; the first uses the most positive pose
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      if (ph == 0)
        load_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      else
        load_pose(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                  rand_coord(), rand_coord(), rand_coord());
      if (ph == RAND_PHASES - 1 || ph == HOLD_PHASE) idle_rate = 0;
      else idle_rate = $urandom_range(0, 3);
      if (ph == HOLD_PHASE) hold_go = 1'b1;
      for (int k = 0; k < PHASE_POINTS; k++) begin
        p.point_x = rand_coord();
        p.point_y = rand_coord();
        p.point_z = rand_coord();
        send_point(p);
      end
    end

    settle();
    if (pose_sb.errors == 0 && pose_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/qpt_pkg.sv
design/qpt_dot3.sv
design/quaternion_pose_point_transform_unit.sv
bench/quaternion_pose_point_transform_unit_tb.sv
